// ===== hw/rtl/fdre_pkg.sv =====
package fdre_pkg;

    localparam int DIVIDER_W = 30;
    localparam int P1_W      = 18;
    localparam int P2_W      = 20;
    localparam int P3_W      = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam int OUT_DIV_MIN = 8;
    localparam int OUT_DIV_MAX = 900;
    localparam int PLL_DIV_MIN = 15;
    localparam int PLL_DIV_MAX = 90;
    localparam int INT_VAL_MAX = 255;

    localparam logic [7:0] OUT_BASE     = 8'd42;
    localparam logic [7:0] PLL_BASE     = 8'd26;
    localparam logic [7:0] INT6_ADDR    = 8'd90;
    localparam logic [7:0] INT7_ADDR    = 8'd91;
    localparam logic [P1_W-1:0] P1_OFFSET = 18'd512;

    localparam logic OP_OUTPUT = 1'b0;
    localparam logic OP_PLL    = 1'b1;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ODD   = 2'd2;
    localparam logic [1:0] ERR_CHAN  = 2'd3;

    typedef enum logic [1:0] {
        KIND_ERR  = 2'd0,
        KIND_INT  = 2'd1,
        KIND_FRAC = 2'd2
    } t_kind;

    // One classified request as handed from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic [1:0]        err;
        logic [7:0]        addr;
        logic [P1_W-1:0]   p1;
        logic [P2_W-1:0]   p2;
        logic [P3_W-1:0]   p3;
    } t_cmd;

endpackage

// ===== hw/rtl/fdre_front.sv =====
module fdre_front
    import fdre_pkg::*;
#(
    parameter int FRACTION_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [2:0]            i_channel,
    input  logic [DIVIDER_W-1:0]  i_divider,
    output logic                  o_push,
    input  logic                  i_full,
    output t_cmd                  o_cmd
);

    localparam int F  = FRACTION_BITS;
    localparam int AW = DIVIDER_W - F;
    localparam logic [DIVIDER_W-1:0] OUT_LO = DIVIDER_W'(OUT_DIV_MIN) << F;
    localparam logic [DIVIDER_W-1:0] OUT_HI = DIVIDER_W'(OUT_DIV_MAX) << F;
    localparam logic [DIVIDER_W-1:0] PLL_LO = DIVIDER_W'(PLL_DIV_MIN) << F;
    localparam logic [DIVIDER_W-1:0] PLL_HI = DIVIDER_W'(PLL_DIV_MAX) << F;

    logic             r_busy;
    t_kind            r_kind;
    logic [1:0]       r_err;
    logic [7:0]       r_addr;
    logic [P1_W-1:0]  r_p1;
    logic [F-1:0]     r_b;
    logic [F-1:0]     r_p2;
    logic [F:0]       r_c;

    t_kind            n_kind;
    logic [1:0]       n_err;
    logic [7:0]       n_addr;
    logic [P1_W-1:0]  n_p1;

    logic [AW-1:0]    w_a;
    logic [F-1:0]     w_b;
    logic             w_done;
    logic             w_accept;
    logic [2:0]       w_shift;
    logic [20:0]      w_c21;
    logic [P2_W-1:0]  w_p2;

    assign w_a = i_divider[DIVIDER_W-1:F];
    assign w_b = i_divider[F-1:0];

    // Classify the request at accept time.
    always_comb begin
        n_kind = KIND_FRAC;
        n_err  = ERR_NONE;
        n_addr = (i_opcode == OP_OUTPUT) ? OUT_BASE + {2'b00, i_channel, 3'b000}
                                         : PLL_BASE + {2'b00, i_channel, 3'b000};
        n_p1   = P1_W'({w_a[9:0], 7'b0000000}) + P1_W'(w_b[F-1:F-7]) - P1_OFFSET;
        if (i_opcode == OP_PLL && i_channel >= 3'd2) begin
            n_kind = KIND_ERR;
            n_err  = ERR_CHAN;
        end else if ((i_opcode == OP_OUTPUT && (i_divider < OUT_LO || i_divider > OUT_HI)) ||
                     (i_opcode == OP_PLL && (i_divider < PLL_LO || i_divider > PLL_HI))) begin
            n_kind = KIND_ERR;
            n_err  = ERR_RANGE;
        end else if (i_opcode == OP_OUTPUT && i_channel >= 3'd6) begin
            n_addr = (i_channel == 3'd6) ? INT6_ADDR : INT7_ADDR;
            n_p1   = P1_W'(w_a[7:0]);
            if (w_a > AW'(INT_VAL_MAX)) begin
                n_kind = KIND_ERR;
                n_err  = ERR_RANGE;
            end else if (w_a[0]) begin
                n_kind = KIND_ERR;
                n_err  = ERR_ODD;
            end else begin
                n_kind = KIND_INT;
            end
        end
    end

    // The fraction is reduced by right shifts of one to four bits until its numerator is odd or zero.
    assign w_done = (r_kind != KIND_FRAC) || r_b[0] || (r_b == '0);

    always_comb begin
        if (r_b[1]) begin
            w_shift = 3'd1;
        end else if (r_b[2]) begin
            w_shift = 3'd2;
        end else if (r_b[3]) begin
            w_shift = 3'd3;
        end else begin
            w_shift = 3'd4;
        end
    end

    assign o_push   = r_busy && w_done && !i_full;
    assign o_ready  = !r_busy || o_push;
    assign w_accept = i_valid && o_ready;

    // A zero fraction leaves the denominator at one.
    assign w_c21 = (r_b == '0) ? 21'd1 : 21'(r_c);
    assign w_p2  = P2_W'(r_p2);

    always_comb begin
        o_cmd.kind = r_kind;
        o_cmd.err  = r_err;
        o_cmd.addr = r_addr;
        o_cmd.p1   = r_p1;
        if (w_c21[20]) begin
            o_cmd.p3 = w_c21[20:1];
            o_cmd.p2 = w_p2 >> 1;
        end else begin
            o_cmd.p3 = w_c21[19:0];
            o_cmd.p2 = w_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (o_push) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= n_kind;
            r_err  <= n_err;
            r_addr <= n_addr;
            r_p1   <= n_p1;
            r_b    <= w_b;
            r_p2   <= {w_b[F-8:0], 7'b0000000};
            r_c    <= (F+1)'(1) << F;
        end else if (r_busy && !w_done) begin
            r_b  <= r_b >> w_shift;
            r_p2 <= r_p2 >> w_shift;
            r_c  <= r_c >> w_shift;
        end
    end

endmodule

// ===== hw/rtl/fdre_fifo.sv =====
module fdre_fifo
    import fdre_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_cmd  o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_count;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/fdre_back.sv =====
module fdre_back
    import fdre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [15:0] o_tdata,
    output logic [1:0]  o_tuser,
    output logic        o_tlast
);

    logic        r_tvalid;
    logic [15:0] r_tdata;
    logic [1:0]  r_tuser;
    logic        r_tlast;
    logic [2:0]  r_idx;

    logic        w_load;
    logic        w_lastbeat;
    logic [7:0]  w_addr;
    logic [7:0]  w_byte;

    assign w_load     = i_valid && (!r_tvalid || i_tready);
    assign w_lastbeat = (i_cmd.kind != KIND_FRAC) || (r_idx == 3'd7);
    assign o_pop      = w_load && w_lastbeat;

    always_comb begin
        case (r_idx)
            3'd0:    w_byte = i_cmd.p3[15:8];
            3'd1:    w_byte = i_cmd.p3[7:0];
            3'd2:    w_byte = {6'b000000, i_cmd.p1[17:16]};
            3'd3:    w_byte = i_cmd.p1[15:8];
            3'd4:    w_byte = i_cmd.p1[7:0];
            3'd5:    w_byte = {i_cmd.p3[19:16], i_cmd.p2[19:16]};
            3'd6:    w_byte = i_cmd.p2[15:8];
            3'd7:    w_byte = i_cmd.p2[7:0];
            default: w_byte = 8'h00;
        endcase
        w_addr = i_cmd.addr + {5'b00000, r_idx};
        case (i_cmd.kind)
            KIND_ERR: begin
                w_addr = 8'h00;
                w_byte = 8'h00;
            end
            KIND_INT: begin
                w_addr = i_cmd.addr;
                w_byte = i_cmd.p1[7:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= 3'd0;
        end else begin
            if (w_load) begin
                r_tvalid <= 1'b1;
                r_idx    <= w_lastbeat ? 3'd0 : r_idx + 3'd1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= {w_byte, w_addr};
            r_tuser <= (i_cmd.kind == KIND_ERR) ? i_cmd.err : ERR_NONE;
            r_tlast <= w_lastbeat;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

// ===== hw/rtl/fractional_divider_register_encoder_top.sv =====
// An accepted request is registered in the front, queued, then registered as a beat in
// the back; the front first reduces a fraction by up to four bits per cycle. The back
// emits one register beat per cycle while the sink is ready: 8 beats for a fractional
// request, 1 for an error or integer one; a 4-entry queue decouples front and back.
// Reset (synchronous, active low) empties the queue and drops any beat in flight.
module fractional_divider_register_encoder_top
    import fdre_pkg::*;
#(
    parameter int FRACTION_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // opcode, channel[2:0], divider[29:0], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // reg_value[7:0], reg_address[7:0]
    output logic [1:0]  o_m_tuser,   // error_code[1:0]
    output logic        o_m_tlast
);

    logic  w_push;
    logic  w_full;
    logic  w_qvalid;
    logic  w_pop;
    t_cmd  w_cmd_in;
    t_cmd  w_cmd_out;

    fdre_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_opcode  (i_s_tdata[0]),
        .i_channel (i_s_tdata[3:1]),
        .i_divider (i_s_tdata[33:4]),
        .o_push    (w_push),
        .i_full    (w_full),
        .o_cmd     (w_cmd_in)
    );

    fdre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out)
    );

    fdre_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule
